// ===== rtl/core/fha_pkg.sv =====
// ---------------------------------------------------------------------------
// fha_pkg: shared types and codes for the failover history table
// Entry layout, operation and reason codes, and the command that steers the
// row of history cells.
// ---------------------------------------------------------------------------
package fha_pkg;

	localparam int unsigned ID_W  = 64;
	localparam int unsigned SEQ_W = 64;

	localparam logic [2:0] OP_CREATE   = 3'd0;
	localparam logic [2:0] OP_PRUNE    = 3'd1;
	localparam logic [2:0] OP_REMOVE   = 3'd2;
	localparam logic [2:0] OP_ROLLBACK = 3'd3;
	localparam logic [2:0] OP_LOOKUP   = 3'd4;

	localparam logic [1:0] RSN_NONE      = 2'd0;
	localparam logic [1:0] RSN_PURGED    = 2'd1;
	localparam logic [1:0] RSN_NOT_FOUND = 2'd2;
	localparam logic [1:0] RSN_AHEAD     = 2'd3;

	typedef struct packed {
		logic             v;
		logic [ID_W-1:0]  id;
		logic [SEQ_W-1:0] seq;
	} fha_entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD      = 3'd0,
		CELL_ROTATE    = 3'd1,
		CELL_MARK      = 3'd2,
		CELL_SWAP_EVEN = 3'd3,
		CELL_SWAP_ODD  = 3'd4,
		CELL_PUSH      = 3'd5,
		CELL_POP       = 3'd6
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t        cmd;
		logic [SEQ_W-1:0] bound;
		fha_entry_t       fresh;
	} fha_ctl_t;

endpackage

// ===== rtl/core/fha_cell.sv =====
// ---------------------------------------------------------------------------
// fha_cell: one history entry
// Holds one entry and trades it with its neighbors as the command asks:
// rotate, mark, odd-even compaction swap, push and pop.
// ---------------------------------------------------------------------------
module fha_cell #(
	parameter int IDX  = 0,
	parameter bit LAST = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fha_pkg::fha_ctl_t   ctl,
	input  logic                keep,
	input  fha_pkg::fha_entry_t left,
	input  fha_pkg::fha_entry_t right,
	output fha_pkg::fha_entry_t ent
);
	import fha_pkg::*;

	localparam bit ODD_POS = (IDX % 2) == 1;

	logic             v_q;
	logic [ID_W-1:0]  id_q;
	logic [SEQ_W-1:0] seq_q;
	fha_entry_t       cur;
	fha_entry_t       nxt;
	logic             ph;
	logic             pair_r;
	logic             pair_l;

	assign cur = {v_q, id_q, seq_q};

	always_comb begin
		nxt    = cur;
		ph     = (ctl.cmd == CELL_SWAP_ODD);
		pair_r = (ODD_POS == ph) && !LAST;
		pair_l = (ODD_POS != ph) && (IDX > 0);
		unique case (ctl.cmd)
			CELL_ROTATE: nxt = right;
			CELL_MARK: begin
				if (cur.seq > ctl.bound) nxt.v = 1'b0;
			end
			CELL_SWAP_EVEN, CELL_SWAP_ODD: begin
				// move a live entry down into a hole; order of live entries holds
				if (pair_r && !cur.v && right.v) nxt = right;
				else if (pair_l && !left.v && cur.v) nxt = left;
			end
			CELL_PUSH: begin
				nxt   = left;
				nxt.v = left.v & keep;
			end
			CELL_POP: begin
				if (LAST) nxt.v = 1'b0;
				else nxt = right;
			end
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else v_q <= nxt.v;
	end

	always_ff @(posedge clk) begin
		id_q  <= nxt.id;
		seq_q <= nxt.seq;
	end

	assign ent = cur;

endmodule

// ===== rtl/core/failover_history_table.sv =====
// ---------------------------------------------------------------------------
// failover_history_table: newest-first history of identifier/seqno pairs
// Row of entry cells driven by a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one operation item; output
//   channel out_valid/out_stall returns exactly one result item per input.
//   entry_limit is written through cfg_we/cfg_wdata while the block is idle.
// Sequence:
//   Create and non-zero prune: a mark step, odd-even compaction rounds, a
//   scan of the whole row and a finish step.
//   Other operations: a scan of the whole row and a finish step.
//   The steps are set by the cell row: compaction is odd-even swaps between
//   neighbors, and the scan rotates the whole row past cell 0 once.
//   One item is in work at a time; the next is taken after the finish cycle.
// Stall:
//   The result sits in an output register; finish waits while it is stalled.
// Reset:
//   Table empty, newest identifier zero, entry_limit 32, no result pending.
// ---------------------------------------------------------------------------
module failover_history_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [5:0]                 cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 operation,
	input  logic [fha_pkg::SEQ_W-1:0]  seqno,
	input  logic [fha_pkg::ID_W-1:0]   uuid,
	input  logic [fha_pkg::SEQ_W-1:0]  local_high_seqno,
	input  logic [fha_pkg::SEQ_W-1:0]  snap_start,
	input  logic [fha_pkg::SEQ_W-1:0]  snap_end,
	input  logic [fha_pkg::SEQ_W-1:0]  purge_seqno,
	input  logic                       strict_match,
	input  logic                       collection_valid,
	input  logic [fha_pkg::SEQ_W-1:0]  collection_high_seqno,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic                       rollback_needed,
	output logic [1:0]                 rollback_reason,
	output logic [fha_pkg::SEQ_W-1:0]  rollback_seqno,
	output logic [fha_pkg::SEQ_W-1:0]  upper_seqno,
	output logic                       found,
	output logic [fha_pkg::SEQ_W-1:0]  found_seqno,
	output logic [fha_pkg::ID_W-1:0]   head_uuid,
	output logic [5:0]                 entry_count
);
	import fha_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > 6) ? CW : 6;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_MARK    = 5'b00010,
		ST_COMPACT = 5'b00100,
		ST_SCAN    = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	state_t state_q;

	logic [5:0]       limit_q;
	logic [2:0]       op_q;
	logic [SEQ_W-1:0] seq_q, lhi_q, ss_q, se_q, purge_q, ch_q;
	logic [ID_W-1:0]  uuid_q;
	logic             strict_q, cv_q;

	logic [CW-1:0]    step_q;
	logic [CW-1:0]    acc_q;
	logic             hit_q, m0_q, fnd_q;
	logic [SEQ_W-1:0] upper_q, fseq_q, prev_q;
	logic [ID_W-1:0]  head_id_q;
	logic [ID_W-1:0]  newest_q;

	logic             out_valid_q;
	logic             status_q, rb_need_q, found_q;
	logic [1:0]       rb_reason_q;
	logic [SEQ_W-1:0] rb_seq_q, upper_out_q, found_seq_q;
	logic [5:0]       count_q;

	fha_entry_t       ents [TABLE_DEPTH];
	fha_ctl_t         ctl;
	logic [TABLE_DEPTH-1:0] keep;
	logic [TABLE_DEPTH-1:0] vv;

	logic             accept, finish_go, modify, prune_push;
	logic [LW-1:0]    lim_ext;
	logic [CW-1:0]    lim_eff, push_lim, new_cnt, inc_cnt;
	fha_entry_t       head;

	// rollback decision
	logic             skip, allow, rb_need;
	logic [1:0]       rb_reason;
	logic [SEQ_W-1:0] rb_seq, upper_out, e_val, s_val;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign modify    = (operation == OP_CREATE) || ((operation == OP_PRUNE) && (seqno != '0));
	assign prune_push = (op_q == OP_PRUNE) && (seq_q != '0) && (acc_q == '0);
	assign head      = ents[0];

	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0) lim_eff = CW'(1);
		else if (lim_ext > LW'(TABLE_DEPTH)) lim_eff = CW'(TABLE_DEPTH);
		else lim_eff = lim_ext[CW-1:0];
		push_lim = (op_q == OP_CREATE) ? lim_eff : CW'(TABLE_DEPTH);
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		fha_entry_t lft, rgt;
		assign keep[g] = CW'(g) < push_lim;
		assign vv[g]   = ents[g].v;
		if (g == 0) begin : g_l0
			assign lft = ctl.fresh;
		end else begin : g_ln
			assign lft = ents[g-1];
		end
		if (g == TABLE_DEPTH - 1) begin : g_rl
			assign rgt = ents[0];
		end else begin : g_rn
			assign rgt = ents[g+1];
		end
		fha_cell #(
			.IDX  (g),
			.LAST (g == TABLE_DEPTH - 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.keep   (keep[g]),
			.left   (lft),
			.right  (rgt),
			.ent    (ents[g])
		);
	end

	always_comb begin
		ctl.cmd       = CELL_HOLD;
		ctl.bound     = seq_q;
		ctl.fresh.v   = 1'b1;
		ctl.fresh.id  = uuid_q;
		ctl.fresh.seq = seq_q;
		unique case (state_q)
			ST_MARK:    ctl.cmd = CELL_MARK;
			ST_COMPACT: ctl.cmd = step_q[0] ? CELL_SWAP_ODD : CELL_SWAP_EVEN;
			ST_SCAN:    ctl.cmd = CELL_ROTATE;
			ST_FINISH: begin
				if (finish_go) begin
					if ((op_q == OP_CREATE) || prune_push) ctl.cmd = CELL_PUSH;
					else if (op_q == OP_REMOVE) ctl.cmd = CELL_POP;
				end
			end
			default: ctl.cmd = CELL_HOLD;
		endcase
	end

	always_comb begin
		inc_cnt = (acc_q < CW'(TABLE_DEPTH)) ? acc_q + CW'(1) : CW'(TABLE_DEPTH);
		priority if (op_q == OP_CREATE) begin
			new_cnt = (inc_cnt > lim_eff) ? lim_eff : inc_cnt;
		end else if (prune_push) begin
			new_cnt = CW'(1);
		end else if ((op_q == OP_REMOVE) && (acc_q != '0)) begin
			new_cnt = acc_q - CW'(1);
		end else begin
			new_cnt = acc_q;
		end
	end

	always_comb begin
		rb_need   = 1'b0;
		rb_reason = RSN_NONE;
		rb_seq    = '0;
		upper_out = '0;
		skip  = (seq_q == '0) && (!strict_q || (uuid_q == '0));
		allow = cv_q && (seq_q < purge_q) && (seq_q >= ch_q) && (ch_q <= purge_q);
		e_val = (seq_q == ss_q) ? seq_q : se_q;
		s_val = (seq_q == e_val) ? seq_q : ss_q;
		if (!skip) begin
			priority if ((seq_q < purge_q) && (seq_q != '0) && !allow) begin
				rb_need   = 1'b1;
				rb_reason = RSN_PURGED;
			end else if (!hit_q) begin
				rb_need   = 1'b1;
				rb_reason = RSN_NOT_FOUND;
			end else if (e_val > upper_q) begin
				rb_need   = 1'b1;
				rb_reason = RSN_AHEAD;
				rb_seq    = (upper_q < s_val) ? upper_q : s_val;
				upper_out = upper_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 6'd32;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			seq_q    <= seqno;
			uuid_q   <= uuid;
			lhi_q    <= local_high_seqno;
			ss_q     <= snap_start;
			se_q     <= snap_end;
			purge_q  <= purge_seqno;
			strict_q <= strict_match;
			cv_q     <= collection_valid;
			ch_q     <= collection_high_seqno;
			upper_q  <= local_high_seqno;
		end else if ((state_q == ST_SCAN) && head.v && (head.id == uuid_q)) begin
			// last hit in the scan is the oldest match
			upper_q <= (step_q == '0) ? lhi_q : prev_q;
		end
		if (state_q == ST_SCAN) begin
			prev_q <= head.seq;
			if (step_q == '0) head_id_q <= head.id;
		end
		if ((state_q == ST_SCAN) && (step_q != '0) && !fnd_q && head.v && (head.id == uuid_q))
			fseq_q <= prev_q;
		if (finish_go) begin
			status_q    <= (op_q == OP_PRUNE) && (seq_q == '0);
			rb_need_q   <= (op_q == OP_ROLLBACK) && rb_need;
			rb_reason_q <= (op_q == OP_ROLLBACK) ? rb_reason : RSN_NONE;
			rb_seq_q    <= (op_q == OP_ROLLBACK) ? rb_seq : '0;
			upper_out_q <= (op_q == OP_ROLLBACK) ? upper_out : '0;
			found_q     <= (op_q == OP_LOOKUP) && fnd_q && !m0_q;
			found_seq_q <= ((op_q == OP_LOOKUP) && fnd_q && !m0_q) ? fseq_q : '0;
			count_q     <= new_cnt[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			acc_q       <= '0;
			hit_q       <= 1'b0;
			m0_q        <= 1'b0;
			fnd_q       <= 1'b0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= modify ? ST_MARK : ST_SCAN;
						step_q  <= '0;
						acc_q   <= '0;
						hit_q   <= 1'b0;
						m0_q    <= 1'b0;
						fnd_q   <= 1'b0;
					end
				end
				ST_MARK: begin
					state_q <= ST_COMPACT;
					step_q  <= '0;
				end
				ST_COMPACT: begin
					if (step_q == CW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_SCAN;
						step_q  <= '0;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_SCAN: begin
					if (head.v) begin
						acc_q <= acc_q + CW'(1);
						if (head.id == uuid_q) begin
							hit_q <= 1'b1;
							if (step_q == '0) m0_q <= 1'b1;
							else fnd_q <= 1'b1;
						end
					end
					if (step_q == CW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_FINISH;
						step_q  <= '0;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (op_q == OP_CREATE) newest_q <= uuid_q;
						else if ((op_q == OP_PRUNE) && (seq_q != '0))
							newest_q <= (acc_q == '0) ? uuid_q : head_id_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign rollback_needed = rb_need_q;
	assign rollback_reason = rb_reason_q;
	assign rollback_seqno  = rb_seq_q;
	assign upper_seqno     = upper_out_q;
	assign found           = found_q;
	assign found_seqno     = found_seq_q;
	assign head_uuid       = newest_q;
	assign entry_count     = count_q;

	// live entries always sit at the front of the row between items
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (((vv + TABLE_DEPTH'(1)) & vv) == '0))
		else $error("live entries not contiguous from the front");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!rollback_needed && !found))
		else $error("rejected prune carries other results");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finish did not post a result");

endmodule
